[rtl/rpc_pkg.sv]
package rpc_pkg;

    // Array size and derived widths
    localparam int MAX_N    = 1024;
    localparam int IDX_W    = 10;                   // element position
    localparam int VAL_W    = 11;                   // element value
    localparam int LEN_W    = 11;                   // range end / length, 0..MAX_N
    localparam int NODE_W   = 11;                   // tree node address, 2*MAX_N nodes
    localparam int PTR_W    = 12;                   // query walk pointer, up to 2*MAX_N
    localparam int VS_W     = 21;                   // node value sum
    localparam int HS_W     = 42;                   // node hash sum
    localparam int TRI_W    = 20;                   // len*(len+1)/2 for len <= MAX_N
    localparam int HASH_W   = 32;
    localparam int BIT_W    = 4;                    // index over the VAL_W exponent bits

    localparam logic [HASH_W-1:0] HASH_BASE = 32'd113;

    // Request operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // 113^(2^k) mod 2^32, evaluated at elaboration only
    function automatic logic [HASH_W-1:0] hash_pow(input int unsigned k);
        logic [HASH_W-1:0] b;
        b = HASH_BASE;
        for (int unsigned i = 0; i < k; i++) begin
            b = b * b;
        end
        return b;
    endfunction

    localparam logic [HASH_W-1:0] HASH_POW [0:VAL_W-1] = '{
        hash_pow(0), hash_pow(1), hash_pow(2), hash_pow(3), hash_pow(4), hash_pow(5),
        hash_pow(6), hash_pow(7), hash_pow(8), hash_pow(9), hash_pow(10)
    };

    // One tree node: value sum and hash sum
    typedef struct packed {
        logic [VS_W-1:0] vs;
        logic [HS_W-1:0] hs;
    } t_node;

    // One expected-sum entry for a given range length
    typedef struct packed {
        logic [TRI_W-1:0] tri_sum;
        logic [HS_W-1:0]  hs;
    } t_exp;

    // Status from the hash unit
    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] hash;
    } t_hash_sts;

    function automatic t_node node_add(input t_node a, input t_node b);
        t_node s;
        s.vs = a.vs + b.vs;
        s.hs = a.hs + b.hs;
        return s;
    endfunction

endpackage

[rtl/rpc_hash_unit.sv]
module rpc_hash_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rpc_pkg::VAL_W-1:0] i_value,
    output rpc_pkg::t_hash_sts        o_sts
);
    import rpc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [BIT_W-1:0]  r_bit;
    logic [VAL_W-1:0]  r_val;
    logic [HASH_W-1:0] r_res;
    logic [2*HASH_W-1:0] w_prod;

    // Shared 32x32 multiplier: one exponent bit per cycle
    assign w_prod = r_res * HASH_POW[r_bit];

    // Multiply sequencer over the value bits, lowest first, using the table of 113^(2^k)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_bit == BIT_W'(VAL_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= '0;
                r_val  <= i_value;
                r_res  <= HASH_W'(1);
            end else if (r_busy) begin
                if (r_val[r_bit]) begin
                    r_res <= w_prod[HASH_W-1:0];
                end
                if (r_bit == BIT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_bit <= r_bit + BIT_W'(1);
                end
            end
        end
    end

    // An empty element hashes to zero
    assign o_sts.done = r_done;
    assign o_sts.hash = (r_val == '0) ? '0 : r_res;

endmodule

[rtl/range_permutation_checker.sv]
// Range permutation checker. Holds 1024 element values in a sum tree whose nodes keep the
// value sum and the sum of hashes 113^v mod 2^32. A request with tuser low writes
// tdata index/value and returns nothing; a request with tuser high asks whether
// [index, range_end) holds exactly 1..len and returns one result: tdata[0] is the answer,
// tuser flags an empty range or one ending past 1024. After reset the block clears the
// node memory and builds the expected-sum table before it takes requests. A write runs
// from acceptance through 11 multiply steps of the shared 32x32 hash multiplier and the
// hand-over of the hash, then one leaf write and one write per tree level (10) on the
// node memory. A query runs from acceptance through one walk step per tree level (up to
// 11, two node reads each), a step to gather the last reads and a result step; an
// out-of-range query goes from acceptance straight to the result step. A new result that
// finds an earlier one held by a stalled receiver holds the block. One request at a time.
module range_permutation_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // index[9:0], value[20:10], range_end[31:21]
    input  logic        i_s_axis_tuser,   // op: 0 write, 1 query
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // is_permutation[0], zero fill [7:1]
    output logic        o_m_axis_tuser    // range_error
);
    import rpc_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_HASH   = 7'b0000100,
        ST_LEAF   = 7'b0001000,
        ST_UP     = 7'b0010000,
        ST_QRY    = 7'b0100000,
        ST_RESULT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Memories
    t_node tree_mem [0:2*MAX_N-1];
    t_exp  exp_mem  [0:MAX_N];

    t_node             r_rd_a, r_rd_b;
    t_exp              r_exp_rd;

    logic [NODE_W-1:0] r_clr;
    logic [HASH_W-1:0] r_pw;
    logic [HS_W-1:0]   r_eh;
    logic [TRI_W-1:0]  r_tri;

    logic [IDX_W-1:0]  r_idx;
    logic [VAL_W-1:0]  r_val;
    logic [NODE_W-1:0] r_node;
    t_node             r_cur;
    logic [PTR_W-1:0]  r_lo, r_hi;
    logic              r_use_a, r_use_b;
    t_node             r_acc;
    logic [LEN_W-1:0]  r_len;
    logic              r_err;

    logic              r_m_valid;
    logic              r_m_perm;
    logic              r_m_err;

    logic              w_s_acc;
    logic              w_op;
    logic [IDX_W-1:0]  w_index;
    logic [VAL_W-1:0]  w_value;
    logic [LEN_W-1:0]  w_end;
    logic              w_bad;
    logic              w_we;
    logic [NODE_W-1:0] w_waddr;
    t_node             w_wdata;
    logic [NODE_W-1:0] w_raddr_a, w_raddr_b;
    logic              w_hash_start;
    t_hash_sts         w_hash;
    logic [NODE_W-1:0] w_leaf;
    t_node             w_leaf_data;
    logic [NODE_W-1:0] w_parent;
    t_node             w_sum_up;
    logic [PTR_W-1:0]  w_hi_m1;
    logic              w_walk;
    t_node             w_part_a, w_part_b;
    logic              w_ok;
    logic              w_m_load;

    // Request fields
    assign w_op    = i_s_axis_tuser;
    assign w_index = i_s_axis_tdata[9:0];
    assign w_value = i_s_axis_tdata[20:10];
    assign w_end   = i_s_axis_tdata[31:21];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    // Empty range or end past the array
    assign w_bad = (w_end <= LEN_W'(w_index)) || (w_end > LEN_W'(MAX_N));

    // Hash of the written value
    rpc_hash_unit u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_value (w_value),
        .o_sts   (w_hash)
    );

    // Tree climb helpers
    assign w_leaf         = NODE_W'(MAX_N) + NODE_W'(r_idx);
    assign w_leaf_data.vs = VS_W'(r_val);
    assign w_leaf_data.hs = HS_W'(w_hash.hash);
    assign w_parent       = r_node >> 1;
    assign w_sum_up       = node_add(r_cur, r_rd_a);

    // Query walk helpers
    assign w_hi_m1  = r_hi - PTR_W'(1);
    assign w_walk   = (r_lo < r_hi);
    assign w_part_a = r_use_a ? r_rd_a : '0;
    assign w_part_b = r_use_b ? r_rd_b : '0;

    // Verdict against the expected sums for this length
    assign w_ok = (r_acc.vs == VS_W'(r_exp_rd.tri_sum)) && (r_acc.hs == r_exp_rd.hs);

    assign w_m_load = (r_state == ST_RESULT) && (!r_m_valid || i_m_axis_tready);

    // Sequencer and node memory port control
    always_comb begin
        n_state      = r_state;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_raddr_a    = '0;
        w_raddr_b    = '0;
        w_hash_start = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_s_acc) begin
                    if (w_op == OP_WRITE) begin
                        w_hash_start = 1'b1;
                        n_state      = ST_HASH;
                    end else if (w_bad) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_QRY;
                    end
                end
            end
            ST_HASH: begin
                if (w_hash.done) begin
                    n_state = ST_LEAF;
                end
            end
            ST_LEAF: begin
                w_we      = 1'b1;
                w_waddr   = w_leaf;
                w_wdata   = w_leaf_data;
                w_raddr_a = w_leaf ^ NODE_W'(1);
                n_state   = ST_UP;
            end
            ST_UP: begin
                w_we      = 1'b1;
                w_waddr   = w_parent;
                w_wdata   = w_sum_up;
                w_raddr_a = w_parent ^ NODE_W'(1);
                if (w_parent == NODE_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QRY: begin
                w_raddr_a = r_lo[NODE_W-1:0];
                w_raddr_b = w_hi_m1[NODE_W-1:0];
                if (!w_walk) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_m_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Node memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            tree_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= tree_mem[w_raddr_a];
        r_rd_b <= tree_mem[w_raddr_b];
    end

    // Expected sums per length, filled during the clearing pass
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_CLEAR) && (r_clr <= NODE_W'(MAX_N))) begin
            exp_mem[r_clr] <= {r_tri, r_eh};
        end
        r_exp_rd <= exp_mem[r_len];
    end

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_pw      <= HASH_BASE;
            r_eh      <= '0;
            r_tri     <= '0;
            r_use_a   <= 1'b0;
            r_use_b   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // clearing pass: running power and prefix sums
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + NODE_W'(1);
                r_pw  <= r_pw * HASH_BASE;
                r_eh  <= r_eh + HS_W'(r_pw);
                r_tri <= r_tri + TRI_W'(r_clr) + TRI_W'(1);
            end

            // take a request
            if (w_s_acc) begin
                r_idx <= w_index;
                r_val <= w_value;
                r_err <= (w_op == OP_QUERY) && w_bad;
                r_lo  <= PTR_W'(w_index) + PTR_W'(MAX_N);
                r_hi  <= PTR_W'(w_end) + PTR_W'(MAX_N);
                r_len <= w_end - LEN_W'(w_index);
                r_acc <= '0;
            end

            // climb from leaf to root
            if (r_state == ST_LEAF) begin
                r_node <= w_leaf;
                r_cur  <= w_leaf_data;
            end else if (r_state == ST_UP) begin
                r_node <= w_parent;
                r_cur  <= w_sum_up;
            end

            // range walk: gather last cycle's reads, issue this level's
            if (r_state == ST_QRY) begin
                r_acc   <= node_add(r_acc, node_add(w_part_a, w_part_b));
                r_use_a <= w_walk && r_lo[0];
                r_use_b <= w_walk && r_hi[0];
                if (w_walk) begin
                    r_lo <= (r_lo + PTR_W'(r_lo[0])) >> 1;
                    r_hi <= (r_hi - PTR_W'(r_hi[0])) >> 1;
                end
            end else begin
                r_use_a <= 1'b0;
                r_use_b <= 1'b0;
            end

            // output register
            if (w_m_load) begin
                r_m_valid <= 1'b1;
                r_m_perm  <= w_ok && !r_err;
                r_m_err   <= r_err;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'b0, r_m_perm};
    assign o_m_axis_tuser  = r_m_err;

    // A new result only ever comes out of the result state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == ST_RESULT))
        else $error("result appeared outside the result state");

    // A range error is never answered yes
    a_err_no_yes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser && o_m_axis_tdata[0]))
        else $error("range error reported with a positive answer");

    // The climb never passes the root
    a_climb_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UP) |-> (r_node > NODE_W'(1)))
        else $error("tree climb beyond the root");

    // The walk pointers stay inside the tree
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QRY) |-> (r_hi <= PTR_W'(2 * MAX_N)) && (r_lo <= PTR_W'(2 * MAX_N)))
        else $error("range walk pointer out of the tree");

endmodule

[bench/range_permutation_checker_test.sv]
module range_permutation_checker_test;
    import rpc_pkg::*;

    localparam int   RANDOM_ITEMS = 420;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   TAIL_CYCLES  = 60;
    localparam int   RUN_LIMIT    = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // index[9:0], value[20:10], range_end[31:21]
    logic        i_s_axis_tuser;   // op: 0 write, 1 query
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;   // is_permutation[0], zero fill [7:1]
    logic        o_m_axis_tuser;   // range_error

    range_permutation_checker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    typedef struct packed {
        logic is_perm;
        logic range_err;
    } t_perm_answer;

    // Mirror of the element array; answers each query by summing the range directly
    class t_perm_scoreboard;
        logic [VAL_W-1:0]  elem_val  [0:MAX_N-1];
        logic [HASH_W-1:0] elem_hash [0:MAX_N-1];
        longint unsigned   prefix_hash [0:MAX_N];   // sum of 113^k for k = 1..len
        t_perm_answer      awaited [$];
        int                errors;
        int                writes;
        int                queries;
        int                yes_count;
        int                bad_range_count;

        function new();
            logic [HASH_W-1:0] p;
            p = 1;
            prefix_hash[0] = 0;
            for (int k = 1; k <= MAX_N; k++) begin
                p = p * HASH_BASE;
                prefix_hash[k] = prefix_hash[k-1] + p;
            end
            for (int i = 0; i < MAX_N; i++) begin
                elem_val[i]  = '0;
                elem_hash[i] = '0;
            end
            errors          = 0;
            writes          = 0;
            queries         = 0;
            yes_count       = 0;
            bad_range_count = 0;
        endfunction

        // zero stands for an empty slot and hashes to zero
        function logic [HASH_W-1:0] hash_power(int unsigned e);
            logic [HASH_W-1:0] acc;
            acc = (e == 0) ? '0 : 1;
            for (int unsigned i = 0; i < e; i++) begin
                acc = acc * HASH_BASE;
            end
            return acc;
        endfunction

        function void note_request(logic op, logic [IDX_W-1:0] idx,
                                   logic [VAL_W-1:0] val, logic [LEN_W-1:0] rend);
            t_perm_answer    ans;
            longint unsigned vsum;
            longint unsigned hsum;
            longint unsigned len;
            if (op == OP_WRITE) begin
                elem_val[idx]  = val;
                elem_hash[idx] = hash_power(int'(val));
                writes++;
                return;
            end
            queries++;
            if (rend <= idx || rend > MAX_N) begin
                ans.is_perm   = 1'b0;
                ans.range_err = 1'b1;
                bad_range_count++;
            end else begin
                len  = rend - idx;
                vsum = 0;
                hsum = 0;
                for (int i = idx; i < rend; i++) begin
                    vsum += elem_val[i];
                    hsum += elem_hash[i];
                end
                ans.is_perm   = (vsum == len * (len + 1) / 2) && (hsum == prefix_hash[len]);
                ans.range_err = 1'b0;
                if (ans.is_perm) yes_count++;
            end
            awaited.push_back(ans);
        endfunction

        function void check_answer(logic [7:0] data, logic user);
            t_perm_answer want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got tdata=%h tuser=%b",
                         $time, data, user);
                return;
            end
            want = awaited.pop_front();
            if (data[0] !== want.is_perm) begin
                errors++;
                $display("%0t: is_permutation mismatch, expected %b, got %b",
                         $time, want.is_perm, data[0]);
            end
            if (data[7:1] !== 7'd0) begin
                errors++;
                $display("%0t: tdata fill mismatch, expected 0000000, got %b",
                         $time, data[7:1]);
            end
            if (user !== want.range_err) begin
                errors++;
                $display("%0t: range_error mismatch, expected %b, got %b",
                         $time, want.range_err, user);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    t_perm_scoreboard sb;
    int             sent;
    bit             quiet;          // no random idle gaps on either side while set
    bit             hold_off_req;   // asks the result side for one long stall

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)  return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // Result side: random back-pressure, checks every accepted result
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_answer(o_m_axis_tdata, o_m_axis_tuser);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                stall_left = idle_length();
                i_m_axis_tready <= (stall_left == 0);
            end
        end
    end

    // Offer one request after a gap and hold it until ready is seen high
    task automatic push_request(input logic op, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] val, input logic [LEN_W-1:0] rend,
                                input int gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {rend, val, idx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_request(op, idx, val, rend);
        sent++;
    endtask

    task automatic write_elem(input int idx, input int val);
        push_request(OP_WRITE, idx[IDX_W-1:0], val[VAL_W-1:0], LEN_W'($urandom), idle_length());
    endtask

    task automatic ask(input int idx, input int rend);
        push_request(OP_QUERY, idx[IDX_W-1:0], VAL_W'($urandom), rend[LEN_W-1:0], idle_length());
    endtask

    // Stop offering until every pending answer is back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Fill a range with a shuffled 1..len, maybe spoil it, then query it and maybe a nearby range
    task automatic run_block_check();
        int len;
        int start;
        int slot;
        int tmp;
        int r;
        int perm [$];
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 6);
        else if (r < 95) len = $urandom_range(7, 24);
        else             len = $urandom_range(25, 90);
        r = $urandom_range(0, 9);
        if (r == 0)      start = 0;
        else if (r == 1) start = MAX_N - len;
        else             start = $urandom_range(0, MAX_N - len);
        perm = {};
        for (int v = 1; v <= len; v++) perm.push_back(v);
        for (int i = len - 1; i > 0; i--) begin
            slot       = $urandom_range(0, i);
            tmp        = perm[i];
            perm[i]    = perm[slot];
            perm[slot] = tmp;
        end
        foreach (perm[i]) write_elem(start + i, perm[i]);
        r = $urandom_range(0, 99);
        if (r < 15)
            write_elem(start + $urandom_range(0, len - 1), $urandom_range(0, 2047));
        else if (r < 25)
            write_elem(start + $urandom_range(0, len - 1), perm[$urandom_range(0, len - 1)]);
        ask(start, start + len);
        r = $urandom_range(0, 99);
        if (r < 10)
            ask(start, start + len + 1);
        else if (r < 20 && len > 1)
            ask(start + 1, start + len);
        else if (r < 30)
            ask(start, start + $urandom_range(1, len));
    endtask

    // Run limit
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        int  r;
        int  target;
        bit  held;
        bit  paused;
        sb           = new();
        sent         = 0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        held         = 1'b0;
        paused       = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: cleared store, bad ranges, range extremes, zero and oversized values
        ask(0, 1);
        ask(5, 5);
        ask(700, 3);
        ask(0, MAX_N + 1);
        ask(1023, 2047);
        ask(0, MAX_N);
        write_elem(0, 1);
        ask(0, 1);
        write_elem(1, 2);
        ask(0, 2);
        ask(1, 2);
        write_elem(1023, 1024);
        write_elem(1022, 2047);
        ask(1022, 1024);
        write_elem(1022, 1);
        write_elem(1023, 2);
        ask(1022, 1024);
        write_elem(1023, 0);
        ask(1022, 1024);
        write_elem(512, 11'h555);
        write_elem(341, 11'h2AA);
        ask(10'h2AA, 11'h555);
        ask(341, 342);

        // Random: mostly filled-then-queried ranges, the rest loose requests
        target = sent + RANDOM_ITEMS;
        while (sent < target) begin
            if ($urandom_range(0, 19) == 0) quiet = !quiet;
            if (!held && sent >= 200) begin
                // result side stalls long while requests keep coming
                held         = 1'b1;
                hold_off_req = 1'b1;
                repeat (6) push_request(OP_QUERY, IDX_W'($urandom_range(0, 500)),
                                        VAL_W'($urandom), LEN_W'($urandom_range(501, 1024)),
                                        0);
            end
            if (!paused && sent >= 320) begin
                paused = 1'b1;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                run_block_check();
            else if (r < 80)
                write_elem($urandom_range(0, 1023), $urandom_range(0, 2047));
            else if (r < 90)
                ask($urandom_range(0, 1023), $urandom_range(0, 2047));
            else begin
                r = $urandom_range(0, 1023);
                ask(r, r + $urandom_range(0, 3) - 1);
            end
        end

        // Drain, then let any stray result show up
        quiet = 1'b1;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d writes and %0d queries: %0d answered yes, %0d bad ranges.",
                 sb.writes, sb.queries, sb.yes_count, sb.bad_range_count);
        $display("Long result-side stall and a full drain pause included; %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[range_permutation_checker.f]
rtl/rpc_pkg.sv
rtl/rpc_hash_unit.sv
rtl/range_permutation_checker.sv
bench/range_permutation_checker_test.sv
